### rtl/ipgp_pkg.sv
package ipgp_pkg;

	localparam int STORE_BYTES = 8192;
	localparam int LINE_BYTES  = 40;

	localparam int ADDR_W     = $clog2(STORE_BYTES);
	localparam int ROW_STRIDE = 2 * LINE_BYTES;
	localparam int BASE_MAX   = 127 * ROW_STRIDE + 42 + 1;
	localparam int BASE_W     = $clog2(BASE_MAX + 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef logic [1:0] slot_t;
	localparam slot_t SLOT_HI  = 2'd0;
	localparam slot_t SLOT_MID = 2'd1;
	localparam slot_t SLOT_LO  = 2'd2;

	typedef logic [4:0] colour_t;
	typedef logic [7:0] byte_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_RD1,
		ST_RD2,
		ST_EVAL,
		ST_WR1,
		ST_WR2
	} state_t;

endpackage

### rtl/inverse_group_pixel_pair_port_top.sv
// Pixel port over a byte bitmap for a 20-colour dithered mode. Each pixel is a
// 2-bit slice in two bytes one line apart; writes are read-modify-write of both
// bytes, reads return the decoded colour on the output channel. All bytes go
// through one single-port memory, so one transaction is handled at a time: a
// read steps through ST_WRAP, ST_RD1, ST_RD2, ST_EVAL and raises out_valid on
// leaving ST_EVAL, in that same cycle the input is free again; a held out_stall
// with a result pending keeps it in ST_EVAL. A write adds ST_WR1 and ST_WR2
// unless its colour is above 19, which leaves the store untouched. A byte
// address beyond the store repeats ST_WRAP; in_stall is high while busy. After
// reset all STORE_BYTES (8192) bytes are zeroed, one per cycle, before input.
module inverse_group_pixel_pair_port_top
	import ipgp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [6:0] pixel_col,
	input  logic [6:0] pixel_row,
	input  logic [4:0] write_colour,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] read_colour
);

	state_t              state_q;
	state_t              state_d;
	logic [ADDR_W-1:0]   clr_q;
	logic                func_q;
	logic                wr_ok_q;
	colour_t             colour_q;
	slot_t               slot_q;
	logic [BASE_W-1:0]   base_q;
	logic [ADDR_W-1:0]   a1_q;
	logic [ADDR_W-1:0]   a2_q;
	byte_t               b1_q;
	byte_t               b2_q;
	logic                out_valid_q;
	colour_t             read_colour_q;

	logic [14:0]         div_prod;
	logic [5:0]          col_div3;
	slot_t               col_mod3;
	logic [BASE_W-1:0]   base_d;
	logic                base_over;
	logic [ADDR_W-1:0]   a1_d;
	logic [ADDR_W:0]     a2_sum;
	logic [ADDR_W-1:0]   a2_d;
	logic                accept;
	logic                out_free;

	logic                ram_en;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	byte_t               ram_wdata;
	byte_t               ram_rdata;

	byte_t               cod_b2;
	byte_t               nb1;
	byte_t               nb2;
	colour_t             dec_colour;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// col / 3 via reciprocal, exact for 7-bit columns
	assign div_prod = 15'(pixel_col) * 15'd171;
	assign col_div3 = div_prod[14:9];
	assign col_mod3 = 2'(pixel_col - 7'(3 * col_div3));
	assign base_d   = BASE_W'(pixel_row) * BASE_W'(ROW_STRIDE)
	                + BASE_W'(col_div3) + BASE_W'(1);

	assign base_over = int'(base_q) >= STORE_BYTES;
	assign a1_d      = ADDR_W'(base_q);
	assign a2_sum    = {1'b0, a1_d} + (ADDR_W + 1)'(LINE_BYTES);
	assign a2_d      = (int'(a2_sum) >= STORE_BYTES) ?
	                   ADDR_W'(a2_sum - (ADDR_W + 1)'(STORE_BYTES)) : ADDR_W'(a2_sum);

	assign cod_b2 = (state_q == ST_EVAL) ? ram_rdata : b2_q;

	ipgp_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	ipgp_codec u_codec (
		.b1         (b1_q),
		.b2         (cod_b2),
		.slot       (slot_q),
		.colour     (colour_q),
		.nb1        (nb1),
		.nb2        (nb2),
		.dec_colour (dec_colour)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == ADDR_W'(STORE_BYTES - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_WRAP;
			ST_WRAP:  if (!base_over) state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_EVAL;
			ST_EVAL: begin
				if (func_q == FUNC_WRITE) begin
					state_d = wr_ok_q ? ST_WR1 : ST_IDLE;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_WR1:   state_d = ST_WR2;
			ST_WR2:   state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = a1_q;
		ram_wdata = nb1;
		case (state_q)
			ST_CLEAR: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			ST_RD1: ram_en = 1'b1;
			ST_RD2: begin
				ram_en   = 1'b1;
				ram_addr = a2_q;
			end
			ST_WR1: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			ST_WR2: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = a2_q;
				ram_wdata = nb2;
			end
			default: ram_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
			if (state_q == ST_EVAL && func_q == FUNC_READ && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			colour_q <= write_colour;
			wr_ok_q  <= (write_colour <= 5'd19);
			slot_q   <= col_mod3;
			base_q   <= base_d;
		end
		if (state_q == ST_WRAP) begin
			if (base_over) begin
				base_q <= base_q - BASE_W'(STORE_BYTES);
			end else begin
				a1_q <= a1_d;
				a2_q <= a2_d;
			end
		end
		if (state_q == ST_RD2) b1_q <= ram_rdata;
		if (state_q == ST_EVAL) begin
			b2_q <= ram_rdata;
			if (func_q == FUNC_READ && out_free) read_colour_q <= dec_colour;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_colour = read_colour_q;

`ifndef SYNTHESIS
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_WR1 || state_q == ST_WR2))
		else $error("store written outside clear or write-back");

	a_out_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EVAL) && $past(func_q == FUNC_READ))
		else $error("result raised without a read evaluation");

	a_wb_is_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR1) |-> (func_q == FUNC_WRITE && wr_ok_q) ##1 (state_q == ST_WR2))
		else $error("write-back sequence broken");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> in_stall && !out_valid_q)
		else $error("activity during store clear");
`endif

endmodule

### rtl/ipgp_ram.sv
module ipgp_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

### rtl/ipgp_codec.sv
module ipgp_codec
	import ipgp_pkg::*;
(
	input  byte_t   b1,
	input  byte_t   b2,
	input  slot_t   slot,
	input  colour_t colour,
	output byte_t   nb1,
	output byte_t   nb2,
	output colour_t dec_colour
);

	logic [1:0] grp;
	logic [2:0] pat;
	logic [1:0] p1;
	logic [1:0] p2;
	logic [1:0] s1;
	logic [1:0] s2;
	colour_t    base_c;

	// colour -> group / pattern
	always_comb begin
		if (colour >= 5'd15) begin
			grp = 2'd3;
			pat = 3'(colour - 5'd15);
		end else if (colour >= 5'd10) begin
			grp = 2'd2;
			pat = 3'(colour - 5'd10);
		end else if (colour >= 5'd5) begin
			grp = 2'd1;
			pat = 3'(colour - 5'd5);
		end else begin
			grp = 2'd0;
			pat = colour[2:0];
		end
	end

	always_comb begin
		case (pat)
			3'd1: begin
				p1 = 2'b10;
				p2 = 2'b01;
			end
			3'd2: begin
				p1 = 2'b11;
				p2 = 2'b00;
			end
			3'd3: begin
				p1 = 2'b00;
				p2 = 2'b11;
			end
			3'd4: begin
				p1 = 2'b11;
				p2 = 2'b11;
			end
			default: begin
				p1 = 2'b00;
				p2 = 2'b00;
			end
		endcase
	end

	always_comb begin
		case (slot)
			SLOT_HI: begin
				nb1 = {grp[0], 1'b1, p1, b1[3:0]};
				nb2 = {grp[1], 1'b1, p2, b2[3:0]};
				s1  = b1[5:4];
				s2  = b2[5:4];
			end
			SLOT_MID: begin
				nb1 = {grp[0], 1'b1, b1[5:4], p1, b1[1:0]};
				nb2 = {grp[1], 1'b1, b2[5:4], p2, b2[1:0]};
				s1  = b1[3:2];
				s2  = b2[3:2];
			end
			SLOT_LO: begin
				nb1 = {grp[0], 1'b1, b1[5:2], p1};
				nb2 = {grp[1], 1'b1, b2[5:2], p2};
				s1  = b1[1:0];
				s2  = b2[1:0];
			end
			default: begin
				nb1 = {grp[0], 1'b1, b1[5:0]};
				nb2 = {grp[1], 1'b1, b2[5:0]};
				s1  = 2'b00;
				s2  = 2'b00;
			end
		endcase
	end

	// bytes -> colour
	always_comb begin
		base_c = (b1[7] ? 5'd5 : 5'd0) + (b2[7] ? 5'd10 : 5'd0);
		case (s1)
			2'b00:   dec_colour = base_c + ((s2 == 2'b11) ? 5'd3 : 5'd0);
			2'b10:   dec_colour = base_c + 5'd1;
			2'b11:   dec_colour = base_c + ((s2 == 2'b11) ? 5'd4 : 5'd2);
			default: dec_colour = base_c;
		endcase
	end

endmodule

### tb/tb_inverse_group_pixel_pair_port_top.sv
`timescale 1ns / 100ps

module tb_inverse_group_pixel_pair_port_top
	import ipgp_pkg::*;
();

	localparam int COLOURS     = 20;
	localparam int GROUP_SIZE  = 5;
	localparam int RANDOM_ITEMS = 750;
	localparam int QUIET_ITEMS = 100;
	localparam int HOLD_AT     = 200;
	localparam int HOLD_CYCLES = 300;
	localparam int POOL_GROUPS = 4;
	localparam int POOL_SIZE   = 3 * POOL_GROUPS;

	localparam int PAT_BLANK  = 0;
	localparam int PAT_SPLIT  = 1;
	localparam int PAT_FIRST  = 2;
	localparam int PAT_SECOND = 3;
	localparam int PAT_SOLID  = 4;

	localparam byte_t SLICE_MASK = 8'h30;
	localparam byte_t SLICE_HI   = 8'h20;
	localparam byte_t SLICE_LO   = 8'h10;
	localparam byte_t KEEP_LOW   = 8'h3f;
	localparam byte_t MARK_BIT   = 8'h40;
	localparam byte_t INV_BIT    = 8'h80;

	class pixel_pair_scoreboard;
		byte_t bitmap [STORE_BYTES];
		colour_t pending_reads [$];
		int errors;

		function new();
			foreach (bitmap[i])
				bitmap[i] = '0;
			errors = 0;
		endfunction

		// update the shadow bitmap, queue the colour a read should return
		function void note_input(logic f, logic [6:0] col, logic [6:0] row, colour_t colour);
			int unsigned base, a1, a2, shift, group, pat;
			byte_t b1, b2, mask, s1, s2;
			colour_t c;
			base  = int'(row) * ROW_STRIDE + int'(col) / 3 + 1;
			a1    = base % STORE_BYTES;
			a2    = (base + LINE_BYTES) % STORE_BYTES;
			shift = 2 * (int'(col) % 3);
			b1    = bitmap[a1];
			b2    = bitmap[a2];
			mask  = SLICE_MASK >> shift;
			if (f == FUNC_WRITE) begin
				if (colour >= COLOURS)
					return;
				group = colour / GROUP_SIZE;
				pat   = colour % GROUP_SIZE;
				b1 = (b1 & KEEP_LOW) | MARK_BIT;
				b2 = (b2 & KEEP_LOW) | MARK_BIT;
				if (group[0])
					b1 = b1 | INV_BIT;
				if (group[1])
					b2 = b2 | INV_BIT;
				b1 = b1 & ~mask;
				b2 = b2 & ~mask;
				case (pat)
					PAT_BLANK: ;
					PAT_SPLIT: begin
						b1 = b1 | (SLICE_HI >> shift);
						b2 = b2 | (SLICE_LO >> shift);
					end
					PAT_FIRST:  b1 = b1 | mask;
					PAT_SECOND: b2 = b2 | mask;
					PAT_SOLID: begin
						b1 = b1 | mask;
						b2 = b2 | mask;
					end
					default: ;
				endcase
				bitmap[a1] = b1;
				bitmap[a2] = b2;
			end else begin
				c = '0;
				if (b1[7])
					c = c + 5'd5;
				if (b2[7])
					c = c + 5'd10;
				s1 = byte_t'(b1 << shift) & SLICE_MASK;
				s2 = byte_t'(b2 << shift) & SLICE_MASK;
				if (s1 == 8'h00) begin
					if (s2 == SLICE_MASK)
						c = c + 5'd3;
				end else if (s1 == SLICE_HI) begin
					c = c + 5'd1;
				end else if (s1 == SLICE_MASK) begin
					c = c + ((s2 == SLICE_MASK) ? 5'd4 : 5'd2);
				end
				pending_reads.push_back(c);
			end
		endfunction

		function void check_result(colour_t got);
			colour_t want;
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected read_colour %0d, no read pending", $time, got);
				errors++;
				return;
			end
			want = pending_reads.pop_front();
			if (got !== want) begin
				$display("%0t: read_colour mismatch, expected %0d actual %0d",
					$time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       func = FUNC_WRITE;
	logic [6:0] pixel_col = '0;
	logic [6:0] pixel_row = '0;
	logic [4:0] write_colour = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [4:0] read_colour;

	pixel_pair_scoreboard sb = new();
	int   items_accepted = 0;
	bit   quiet = 1'b0;
	logic [6:0] pool_col [POOL_SIZE];
	logic [6:0] pool_row [POOL_SIZE];

	inverse_group_pixel_pair_port_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.write_colour(write_colour),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_colour (read_colour)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("tb: failure");
		$finish;
	end

	task automatic send_item(input logic f, input logic [6:0] col, input logic [6:0] row,
		input colour_t colour);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		pixel_col    <= col;
		pixel_row    <= row;
		write_colour <= colour;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(f, col, row, colour);
		items_accepted++;
	endtask

	// three neighbouring pixels sharing one byte pair
	task automatic refresh_group(input int g);
		int k;
		logic [6:0] r;
		k = $urandom_range(0, 41);
		r = 7'($urandom_range(0, 127));
		for (int s = 0; s < 3; s++) begin
			pool_col[3 * g + s] = 7'(3 * k + s);
			pool_row[3 * g + s] = r;
		end
	endtask

	task automatic random_item();
		int pick, idx;
		logic f;
		logic [6:0] c, r;
		colour_t w;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			f = 1'($urandom);
			c = 7'($urandom);
			r = 7'($urandom);
			w = 5'($urandom);
		end else begin
			idx = $urandom_range(0, POOL_SIZE - 1);
			c = pool_col[idx];
			r = pool_row[idx];
			f = (pick < 60) ? FUNC_WRITE : FUNC_READ;
			if ($urandom_range(0, 19) == 0)
				w = 5'($urandom_range(COLOURS, 31));
			else
				w = 5'($urandom_range(0, COLOURS - 1));
		end
		send_item(f, c, r, w);
	endtask

	initial begin : result_sink
		int stall_left;
		bit held;
		stall_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_result(read_colour);
			if (!held && items_accepted >= HOLD_AT) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_item(FUNC_READ,  7'd0,   7'd0,   5'd0);
		send_item(FUNC_WRITE, 7'd0,   7'd0,   5'd19);
		send_item(FUNC_READ,  7'd0,   7'd0,   5'd0);
		send_item(FUNC_WRITE, 7'd1,   7'd0,   5'd6);
		send_item(FUNC_WRITE, 7'd2,   7'd0,   5'd12);
		send_item(FUNC_READ,  7'd0,   7'd0,   5'd31);
		send_item(FUNC_READ,  7'd1,   7'd0,   5'd0);
		send_item(FUNC_READ,  7'd2,   7'd0,   5'd0);
		send_item(FUNC_WRITE, 7'd127, 7'd127, 5'd18);
		send_item(FUNC_READ,  7'd127, 7'd127, 5'd0);
		send_item(FUNC_WRITE, 7'd116, 7'd99,  5'd4);
		send_item(FUNC_READ,  7'd116, 7'd99,  5'd0);
		send_item(FUNC_WRITE, 7'd120, 7'd5,   5'd1);
		send_item(FUNC_READ,  7'd0,   7'd5,   5'd0);
		send_item(FUNC_READ,  7'd120, 7'd5,   5'd0);
		send_item(FUNC_WRITE, 7'd0,   7'd0,   5'd31);
		send_item(FUNC_WRITE, 7'd1,   7'd0,   5'd20);
		send_item(FUNC_READ,  7'd0,   7'd0,   5'd0);
		send_item(FUNC_READ,  7'd1,   7'd0,   5'd0);
		send_item(FUNC_WRITE, 7'd5,   7'd127, 5'd0);
		send_item(FUNC_READ,  7'd5,   7'd127, 5'd0);
		send_item(FUNC_WRITE, 7'd64,  7'd64,  5'd13);
		send_item(FUNC_READ,  7'd64,  7'd64,  5'd16);

		for (int g = 0; g < POOL_GROUPS; g++)
			refresh_group(g);
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - QUIET_ITEMS)
				quiet = 1'b1;
			if (n % 25 == 24)
				refresh_group($urandom_range(0, POOL_GROUPS - 1));
			random_item();
		end

		in_valid <= 1'b0;
		while (sb.pending_reads.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.errors == 0 && sb.pending_reads.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
